>>> src/ckc_pkg.sv
// shared types, constants and profile tables for the chroma key correlator
package ckc_pkg;

   localparam int          NUM_PITCH   = 12;
   localparam int          NUM_KEYS    = 24;
   localparam logic [3:0]  LAST_IDX    = 4'd11;
   localparam logic [4:0]  NORM_LAST   = 5'd17;
   localparam logic [4:0]  SQRT_LAST   = 5'd27;
   localparam logic [4:0]  DIV_LAST    = 5'd15;
   localparam logic [4:0]  LAST_KEY    = 5'd23;
   localparam logic [4:0]  UNKNOWN_KEY = 5'd24;
   localparam logic [15:0] DECAY_Q16   = 16'd62259;
   localparam logic [15:0] WEIGHT_RST  = 16'd6554;
   localparam logic [15:0] THRESH_RST  = 16'd9830;
   localparam logic [2:0]  ADDR_WEIGHT = 3'd0;
   localparam logic [2:0]  ADDR_THRESH = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAX, ST_NORM, ST_CHECK, ST_SXX, ST_AMUL, ST_SQRT, ST_SXY,
      ST_NUM, ST_DIV, ST_SM1, ST_SM2, ST_RESULT, ST_DECAY
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_BIN, OP_MAX, OP_NORM, OP_SXX, OP_AMUL, OP_SQRT, OP_SXY,
      OP_NUM, OP_DIV, OP_SM1, OP_SM2, OP_RESULT, OP_DECAY
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [3:0] idx;
      logic [4:0] step;
      logic [4:0] key;
   } cmd_type;

   typedef struct packed {
      logic sum_zero;
      logic out_free;
   } status_type;

   // key profiles scaled by 100
   function automatic logic [9:0] profile(input logic minor, input logic [3:0] i);
      logic [9:0] v;
      v = 10'd0;
      if (!minor) begin
         case (i)
            4'd0: v = 10'd635;  4'd1: v = 10'd223;  4'd2: v = 10'd348;
            4'd3: v = 10'd233;  4'd4: v = 10'd438;  4'd5: v = 10'd409;
            4'd6: v = 10'd252;  4'd7: v = 10'd519;  4'd8: v = 10'd239;
            4'd9: v = 10'd366;  4'd10: v = 10'd229; 4'd11: v = 10'd288;
            default: v = 10'd0;
         endcase
      end else begin
         case (i)
            4'd0: v = 10'd633;  4'd1: v = 10'd268;  4'd2: v = 10'd352;
            4'd3: v = 10'd538;  4'd4: v = 10'd260;  4'd5: v = 10'd353;
            4'd6: v = 10'd254;  4'd7: v = 10'd475;  4'd8: v = 10'd398;
            4'd9: v = 10'd269;  4'd10: v = 10'd334; 4'd11: v = 10'd317;
            default: v = 10'd0;
         endcase
      end
      return v;
   endfunction

   function automatic longint prof_sum(input logic minor, input logic sq);
      longint s;
      longint p;
      s = 0;
      for (int i = 0; i < NUM_PITCH; i++) begin
         p = longint'(profile(minor, 4'(i)));
         s = s + (sq ? p * p : p);
      end
      return s;
   endfunction

   function automatic longint isqrt_const(input longint a);
      longint v;
      longint r;
      longint b;
      v = a;
      r = 0;
      b = longint'(1) << 40;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   localparam longint SY_MAJ_L = prof_sum(1'b0, 1'b0);
   localparam longint SY_MIN_L = prof_sum(1'b1, 1'b0);
   localparam longint B_MAJ    = 12 * prof_sum(1'b0, 1'b1) - SY_MAJ_L * SY_MAJ_L;
   localparam longint B_MIN    = 12 * prof_sum(1'b1, 1'b1) - SY_MIN_L * SY_MIN_L;

   localparam logic [12:0] SY_MAJ    = 13'(SY_MAJ_L);
   localparam logic [12:0] SY_MIN    = 13'(SY_MIN_L);
   localparam logic [11:0] ISQ_B_MAJ = 12'(isqrt_const(B_MAJ));
   localparam logic [11:0] ISQ_B_MIN = 12'(isqrt_const(B_MIN));

endpackage

>>> src/ckc_ctrl.sv
// sequencer for bin intake, per-frame normalize, correlation and decay passes
module ckc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tlast,
   output logic               req_tready,
   input  ckc_pkg::status_type status,
   output ckc_pkg::cmd_type    cmd
);

   ckc_pkg::ctrl_state_type state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic [4:0] step_ff, step_in;
   logic [4:0] kidx_ff, kidx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ckc_pkg::ST_IDLE;
         idx_ff   <= 4'd0;
         step_ff  <= 5'd0;
         kidx_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         kidx_ff  <= kidx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      step_in    = step_ff;
      kidx_in    = kidx_ff;
      req_tready = 1'b0;
      cmd.op     = ckc_pkg::OP_NONE;
      cmd.idx    = idx_ff;
      cmd.step   = step_ff;
      cmd.key    = kidx_ff;
      case (state_ff)
         ckc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = ckc_pkg::OP_BIN;
               if (req_tlast) begin
                  state_in = ckc_pkg::ST_MAX;
                  idx_in   = 4'd0;
               end
            end
         end
         ckc_pkg::ST_MAX: begin
            cmd.op = ckc_pkg::OP_MAX;
            if (idx_ff == ckc_pkg::LAST_IDX) begin
               idx_in   = 4'd0;
               step_in  = 5'd0;
               state_in = ckc_pkg::ST_NORM;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ckc_pkg::ST_NORM: begin
            cmd.op = ckc_pkg::OP_NORM;
            if (step_ff == ckc_pkg::NORM_LAST) begin
               step_in = 5'd0;
               if (idx_ff == ckc_pkg::LAST_IDX) begin
                  idx_in   = 4'd0;
                  state_in = ckc_pkg::ST_CHECK;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ckc_pkg::ST_CHECK: begin
            idx_in   = 4'd0;
            state_in = status.sum_zero ? ckc_pkg::ST_DECAY : ckc_pkg::ST_SXX;
         end
         ckc_pkg::ST_SXX: begin
            cmd.op = ckc_pkg::OP_SXX;
            if (idx_ff == ckc_pkg::LAST_IDX) begin
               idx_in   = 4'd0;
               state_in = ckc_pkg::ST_AMUL;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ckc_pkg::ST_AMUL: begin
            cmd.op   = ckc_pkg::OP_AMUL;
            step_in  = 5'd0;
            state_in = ckc_pkg::ST_SQRT;
         end
         ckc_pkg::ST_SQRT: begin
            cmd.op = ckc_pkg::OP_SQRT;
            if (step_ff == ckc_pkg::SQRT_LAST) begin
               step_in  = 5'd0;
               idx_in   = 4'd0;
               kidx_in  = 5'd0;
               state_in = ckc_pkg::ST_SXY;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ckc_pkg::ST_SXY: begin
            cmd.op = ckc_pkg::OP_SXY;
            if (idx_ff == ckc_pkg::LAST_IDX) begin
               idx_in   = 4'd0;
               state_in = ckc_pkg::ST_NUM;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ckc_pkg::ST_NUM: begin
            cmd.op   = ckc_pkg::OP_NUM;
            step_in  = 5'd0;
            state_in = ckc_pkg::ST_DIV;
         end
         ckc_pkg::ST_DIV: begin
            cmd.op = ckc_pkg::OP_DIV;
            if (step_ff == ckc_pkg::DIV_LAST) begin
               step_in  = 5'd0;
               state_in = ckc_pkg::ST_SM1;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ckc_pkg::ST_SM1: begin
            cmd.op   = ckc_pkg::OP_SM1;
            state_in = ckc_pkg::ST_SM2;
         end
         ckc_pkg::ST_SM2: begin
            cmd.op = ckc_pkg::OP_SM2;
            idx_in = 4'd0;
            if (kidx_ff == ckc_pkg::LAST_KEY) begin
               state_in = ckc_pkg::ST_RESULT;
            end else begin
               kidx_in  = kidx_ff + 5'd1;
               state_in = ckc_pkg::ST_SXY;
            end
         end
         ckc_pkg::ST_RESULT: begin
            if (status.out_free) begin
               cmd.op   = ckc_pkg::OP_RESULT;
               idx_in   = 4'd0;
               state_in = ckc_pkg::ST_DECAY;
            end
         end
         ckc_pkg::ST_DECAY: begin
            cmd.op = ckc_pkg::OP_DECAY;
            if (idx_ff == ckc_pkg::LAST_IDX) begin
               idx_in   = 4'd0;
               state_in = ckc_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         default: begin
            state_in = ckc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/ckc_datapath.sv
// chroma stores, normalize divider, correlation accumulators, square root, smoothing, result
module ckc_datapath #(
   parameter int POWER_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ckc_pkg::cmd_type    cmd,
   input  logic [3:0]          bin_pitch,
   input  logic [31:0]         bin_power,
   input  logic [15:0]         smoothing_weight,
   input  logic [15:0]         detect_threshold,
   input  logic                rsp_tready,
   output ckc_pkg::status_type status,
   output logic                rsp_tvalid,
   output logic [4:0]          key_index,
   output logic [15:0]         confidence,
   output logic [15:0]         best_correlation
);

   localparam int FW  = POWER_WIDTH + 8;
   localparam int PIN = (POWER_WIDTH < 32) ? POWER_WIDTH : 32;
   localparam logic signed [17:0] BEST_FLOOR = -18'sd32768;

   logic [FW-1:0]       frame_ff [12];
   logic [FW-1:0]       frame_in [12];
   logic [23:0]         long_ff  [12];
   logic [23:0]         long_in  [12];
   logic signed [17:0]  smooth_ff [24];
   logic signed [17:0]  smooth_in [24];
   logic [4:0]          key_ff, key_in;
   logic [FW-1:0]       mx_ff, mx_in;
   logic [FW:0]         rem_ff, rem_in;
   logic [16:0]         quo_ff, quo_in;
   logic [27:0]         sum_ff, sum_in;
   logic [51:0]         sxx_ff, sxx_in;
   logic [55:0]         sqv_ff, sqv_in;
   logic [55:0]         sqr_ff, sqr_in;
   logic [55:0]         sqb_ff, sqb_in;
   logic [37:0]         sxy_ff, sxy_in;
   logic signed [43:0]  num_ff, num_in;
   logic [39:0]         den_ff, den_in;
   logic                dneg_ff, dneg_in;
   logic                dsat_ff, dsat_in;
   logic                dzero_ff, dzero_in;
   logic [14:0]         dq_ff, dq_in;
   logic [40:0]         dr_ff, dr_in;
   logic signed [35:0]  prs_ff, prs_in;
   logic signed [35:0]  prc_ff, prc_in;
   logic signed [17:0]  best_ff, best_in;
   logic [4:0]          bkey_ff, bkey_in;
   logic                found_ff, found_in;
   logic                vld_ff, vld_in;
   logic [4:0]          okey_ff, okey_in;
   logic [15:0]         oconf_ff, oconf_in;
   logic [15:0]         obest_ff, obest_in;

   // read ports and shared terms
   logic                pc_ok;
   logic [3:0]          f_addr, l_addr, root;
   logic [4:0]          rot_sum;
   logic [FW-1:0]       rd_f, pw;
   logic [23:0]         rd_l;
   logic                minor;
   logic [9:0]          prof;
   logic [12:0]         sy_sel;
   logic [11:0]         isqb_sel;
   logic [FW:0]         fsum, nsh;
   logic [16:0]         add_q;
   logic [24:0]         lsum;
   logic [23:0]         lnew;
   logic [47:0]         xx;
   logic [33:0]         xy;
   logic [55:0]         a12, sx2;
   logic [55:0]         sqt;
   logic [43:0]         t12, sxsy, mag;
   logic [40:0]         dsh;
   logic [16:0]         inv_w;
   logic signed [15:0]  corr;
   logic signed [36:0]  tsum;
   logic signed [17:0]  ns;
   logic signed [17:0]  thr_ext;
   logic [39:0]         dec_p;

   assign pc_ok   = bin_pitch < 4'd12;
   assign pw      = FW'(bin_power[PIN-1:0]);
   assign f_addr  = (cmd.op == ckc_pkg::OP_BIN && pc_ok) ? bin_pitch : cmd.idx;
   assign minor   = cmd.key > 5'd11;
   assign root    = minor ? 4'(cmd.key - 5'd12) : cmd.key[3:0];
   assign rot_sum = {1'b0, cmd.idx} + {1'b0, root};
   assign l_addr  = (cmd.op != ckc_pkg::OP_SXY) ? cmd.idx :
                    (rot_sum > 5'd11) ? 4'(rot_sum - 5'd12) : rot_sum[3:0];
   assign rd_f    = frame_ff[f_addr];
   assign rd_l    = long_ff[l_addr];
   assign prof    = ckc_pkg::profile(minor, cmd.idx);
   assign sy_sel  = minor ? ckc_pkg::SY_MIN : ckc_pkg::SY_MAJ;
   assign isqb_sel = minor ? ckc_pkg::ISQ_B_MIN : ckc_pkg::ISQ_B_MAJ;
   assign thr_ext = {{2{detect_threshold[15]}}, detect_threshold};

   assign status.sum_zero = (sum_ff == 28'd0);
   assign status.out_free = !vld_ff || rsp_tready;

   assign rsp_tvalid       = vld_ff;
   assign key_index        = okey_ff;
   assign confidence       = oconf_ff;
   assign best_correlation = obest_ff;

   always_comb begin
      frame_in  = frame_ff;
      long_in   = long_ff;
      smooth_in = smooth_ff;
      key_in    = key_ff;
      mx_in     = mx_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      sum_in    = sum_ff;
      sxx_in    = sxx_ff;
      sqv_in    = sqv_ff;
      sqr_in    = sqr_ff;
      sqb_in    = sqb_ff;
      sxy_in    = sxy_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      dneg_in   = dneg_ff;
      dsat_in   = dsat_ff;
      dzero_in  = dzero_ff;
      dq_in     = dq_ff;
      dr_in     = dr_ff;
      prs_in    = prs_ff;
      prc_in    = prc_ff;
      best_in   = best_ff;
      bkey_in   = bkey_ff;
      found_in  = found_ff;
      vld_in    = vld_ff && !rsp_tready;
      okey_in   = okey_ff;
      oconf_in  = oconf_ff;
      obest_in  = obest_ff;

      fsum  = {1'b0, rd_f} + {1'b0, pw};
      nsh   = {rem_ff[FW-1:0], 1'b0};
      add_q = (mx_ff == '0) ? 17'd0 : quo_ff;
      lsum  = {1'b0, rd_l} + {8'd0, add_q};
      lnew  = lsum[24] ? 24'hFFFFFF : lsum[23:0];
      xx    = rd_l * rd_l;
      xy    = rd_l * prof;
      a12   = 56'(sxx_ff) * 56'd12;
      sx2   = sum_ff * sum_ff;
      sqt   = sqr_ff + sqb_ff;
      t12   = 44'(sxy_ff) * 44'd12;
      sxsy  = sum_ff * sy_sel;
      mag   = num_ff[43] ? (~num_ff + 44'd1) : num_ff;
      dsh   = {dr_ff[39:0], 1'b0};
      inv_w = 17'h10000 - {1'b0, smoothing_weight};
      tsum  = 37'(prs_ff) + 37'(prc_ff);
      ns    = tsum[33:16];
      dec_p = rd_l * ckc_pkg::DECAY_Q16;

      if (dzero_ff) begin
         corr = 16'sd0;
      end else if (dsat_ff) begin
         corr = dneg_ff ? 16'sh8000 : 16'sh7FFF;
      end else begin
         corr = dneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
      end

      case (cmd.op)
         ckc_pkg::OP_BIN: begin
            if (pc_ok) begin
               frame_in[bin_pitch] = fsum[FW] ? {FW{1'b1}} : fsum[FW-1:0];
            end
         end
         ckc_pkg::OP_MAX: begin
            sum_in = 28'd0;
            if (cmd.idx == 4'd0 || rd_f > mx_ff) mx_in = rd_f;
         end
         ckc_pkg::OP_NORM: begin
            if (cmd.step == 5'd0) begin
               if (rd_f >= mx_ff) begin
                  rem_in = {1'b0, rd_f - mx_ff};
                  quo_in = 17'd1;
               end else begin
                  rem_in = {1'b0, rd_f};
                  quo_in = 17'd0;
               end
            end else if (cmd.step == ckc_pkg::NORM_LAST) begin
               long_in[cmd.idx] = lnew;
               sum_in = sum_ff + 28'(lnew);
            end else begin
               // restoring divide, one quotient bit per cycle
               if (nsh >= {1'b0, mx_ff}) begin
                  rem_in = nsh - {1'b0, mx_ff};
                  quo_in = {quo_ff[15:0], 1'b1};
               end else begin
                  rem_in = nsh;
                  quo_in = {quo_ff[15:0], 1'b0};
               end
            end
         end
         ckc_pkg::OP_SXX: begin
            sxx_in = ((cmd.idx == 4'd0) ? 52'd0 : sxx_ff) + 52'(xx);
         end
         ckc_pkg::OP_AMUL: begin
            sqv_in = a12 - sx2;
            sqr_in = 56'd0;
            sqb_in = 56'd1 << 54;
         end
         ckc_pkg::OP_SQRT: begin
            if (sqv_ff >= sqt) begin
               sqv_in = sqv_ff - sqt;
               sqr_in = (sqr_ff >> 1) + sqb_ff;
            end else begin
               sqr_in = sqr_ff >> 1;
            end
            sqb_in = sqb_ff >> 2;
         end
         ckc_pkg::OP_SXY: begin
            sxy_in = ((cmd.idx == 4'd0) ? 38'd0 : sxy_ff) + 38'(xy);
         end
         ckc_pkg::OP_NUM: begin
            num_in = $signed(t12 - sxsy);
            den_in = sqr_ff[27:0] * isqb_sel;
         end
         ckc_pkg::OP_DIV: begin
            if (cmd.step == 5'd0) begin
               dneg_in  = num_ff[43];
               dzero_in = (den_ff == 40'd0);
               dsat_in  = mag >= {4'd0, den_ff};
               dr_in    = mag[40:0];
               dq_in    = 15'd0;
            end else if (dsh >= {1'b0, den_ff}) begin
               dr_in = dsh - {1'b0, den_ff};
               dq_in = {dq_ff[13:0], 1'b1};
            end else begin
               dr_in = dsh;
               dq_in = {dq_ff[13:0], 1'b0};
            end
         end
         ckc_pkg::OP_SM1: begin
            prs_in = smooth_ff[cmd.key] * $signed({1'b0, inv_w});
            prc_in = corr * $signed({1'b0, smoothing_weight});
         end
         ckc_pkg::OP_SM2: begin
            smooth_in[cmd.key] = ns;
            if (cmd.key == 5'd0) begin
               found_in = ns > BEST_FLOOR;
               best_in  = (ns > BEST_FLOOR) ? ns : BEST_FLOOR;
               bkey_in  = 5'd0;
            end else if (ns > best_ff) begin
               found_in = 1'b1;
               best_in  = ns;
               bkey_in  = cmd.key;
            end
         end
         ckc_pkg::OP_RESULT: begin
            vld_in   = 1'b1;
            obest_in = best_ff[15:0];
            if (found_ff && best_ff > thr_ext) begin
               key_in   = bkey_ff;
               okey_in  = bkey_ff;
               oconf_in = best_ff[15:0] ^ 16'h8000;
            end else begin
               okey_in  = key_ff;
               oconf_in = 16'd0;
            end
         end
         ckc_pkg::OP_DECAY: begin
            long_in[cmd.idx]  = dec_p[39:16];
            frame_in[cmd.idx] = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ckc_pkg::NUM_PITCH; i++) begin
            frame_ff[i] <= '0;
            long_ff[i]  <= 24'd0;
         end
         for (int k = 0; k < ckc_pkg::NUM_KEYS; k++) begin
            smooth_ff[k] <= 18'sd0;
         end
         key_ff <= ckc_pkg::UNKNOWN_KEY;
         vld_ff <= 1'b0;
         sum_ff <= 28'd0;
      end else begin
         frame_ff  <= frame_in;
         long_ff   <= long_in;
         smooth_ff <= smooth_in;
         key_ff    <= key_in;
         vld_ff    <= vld_in;
         sum_ff    <= sum_in;
      end
      mx_ff    <= mx_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      sxx_ff   <= sxx_in;
      sqv_ff   <= sqv_in;
      sqr_ff   <= sqr_in;
      sqb_ff   <= sqb_in;
      sxy_ff   <= sxy_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      dneg_ff  <= dneg_in;
      dsat_ff  <= dsat_in;
      dzero_ff <= dzero_in;
      dq_ff    <= dq_in;
      dr_ff    <= dr_in;
      prs_ff   <= prs_in;
      prc_ff   <= prc_in;
      best_ff  <= best_in;
      bkey_ff  <= bkey_in;
      found_ff <= found_in;
      okey_ff  <= okey_in;
      oconf_ff <= oconf_in;
      obest_ff <= obest_in;
   end

endmodule

>>> src/chroma_key_correlator_core.sv
// Key finder: ordinary bins are taken while the sequencer is idle and are summed into the
// frame chroma. A bin with tlast set ends the frame and starts a pass after that beat, run by
// the sequencer: a max search, a 16-step divider per chroma entry with setup and write back,
// a check, a sum of squares, a product, a square root, then per key a multiply-accumulate
// over the chroma entries, a numerator, a divide and smoothing (24 keys), the result load and
// a decay of the long-term chroma. An empty long-term chroma goes from the check straight to
// the decay. No bin is taken during the pass, and the result load waits while the previous
// result beat is still not accepted.
module chroma_key_correlator_core #(
   parameter int POWER_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pitch_class[3:0], bin_power[35:4], zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // key_index[4:0], confidence[20:5], best_correlation[36:21]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] weight_ff, weight_in;
   logic [15:0] thresh_ff, thresh_in;
   logic        wr_en;

   ckc_pkg::cmd_type    cmd;
   ckc_pkg::status_type status;
   logic [4:0]  key_index;
   logic [15:0] confidence;
   logic [15:0] best_correlation;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      weight_in = weight_ff;
      thresh_in = thresh_ff;
      if (wr_en) begin
         if (csr_paddr == ckc_pkg::ADDR_THRESH) thresh_in = csr_pwdata[15:0];
         else if (csr_paddr == ckc_pkg::ADDR_WEIGHT) weight_in = csr_pwdata[15:0];
      end
      if (csr_paddr == ckc_pkg::ADDR_WEIGHT) csr_prdata = {16'd0, weight_ff};
      else if (csr_paddr == ckc_pkg::ADDR_THRESH) csr_prdata = {{16{thresh_ff[15]}}, thresh_ff};
      else csr_prdata = 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= ckc_pkg::WEIGHT_RST;
         thresh_ff <= ckc_pkg::THRESH_RST;
      end else begin
         weight_ff <= weight_in;
         thresh_ff <= thresh_in;
      end
   end

   ckc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ckc_datapath #(
      .POWER_WIDTH (POWER_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .bin_pitch        (req_tdata[3:0]),
      .bin_power        (req_tdata[35:4]),
      .smoothing_weight (weight_ff),
      .detect_threshold (thresh_ff),
      .rsp_tready       (rsp_tready),
      .status           (status),
      .rsp_tvalid       (rsp_tvalid),
      .key_index        (key_index),
      .confidence       (confidence),
      .best_correlation (best_correlation)
   );

   assign rsp_tdata = {3'd0, best_correlation, confidence, key_index};

endmodule
